[rtl/core/htiw_pkg.sv]
// Package for the Huffman tree in-order weights unit.
// Holds sizing constants and the sequencer state type.
package htiw_pkg;

    localparam int MAX_LEAVES_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int IN_W            = 16;
    localparam int OUT_W           = 20;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_MERGE,
        ST_WPUSH,
        ST_WPOP,
        ST_WEMIT
    } state_t;

endpackage

[rtl/core/htiw_scan.sv]
// Shared compare unit: walks live nodes one per cycle and keeps the smallest.
// Depends on htiw_pkg.
module htiw_scan #(
    parameter int IDX_W = 6,
    parameter int SUM_W = 37
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             probe,
    input  logic [IDX_W-1:0] idx,
    input  logic [SUM_W-1:0] w,
    output logic             found,
    output logic [IDX_W-1:0] best_idx,
    output logic [SUM_W-1:0] best_w
);
    import htiw_pkg::*;

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [SUM_W-1:0] best_w_reg;

    // strict less-than keeps the lower index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (probe && (!found_reg || w < best_w_reg))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear && probe && (!found_reg || w < best_w_reg))
        begin
            best_idx_reg <= idx;
            best_w_reg   <= w;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best_w   = best_w_reg;
endmodule

[rtl/core/huffman_tree_inorder_weights_unit.sv]
// Top level of the Huffman tree in-order weights unit: sequencer and node stores.
// Depends on htiw_pkg and htiw_scan.
//
//  channel | signals                            | beat taken when
//  --------+------------------------------------+---------------------
//  input   | start, weight, last, busy          | start && !busy
//  result  | res_valid, node_weight, final_res, | every res_valid cycle
//          | dropped                            |
//
// Weights are loaded one per accepted input beat. After last, a setup state
// (ST_INIT) runs, then a build of n leaves makes n-1 merges; each merge is two
// scans of the node store through the shared compare unit, each scan closed by
// a merge state (ST_MERGE). The walk then pushes the left spine (ST_WPUSH), pops
// a node (ST_WPOP) and emits it (ST_WEMIT). busy stays high from last until
// the final result. Reset leaves the unit empty and idle; the receiver cannot
// stall, so results are issued one per strobe.
module huffman_tree_inorder_weights_unit #(
    parameter int MAX_LEAVES  = htiw_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = htiw_pkg::WEIGHT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [htiw_pkg::IN_W-1:0] weight,
    input  logic                      last,
    output logic                      res_valid,
    output logic [htiw_pkg::OUT_W-1:0] node_weight,
    output logic                      final_res,
    output logic                      dropped
);
    import htiw_pkg::*;

    localparam int NCAP  = 2 * MAX_LEAVES;
    localparam int IDX_W = $clog2(NCAP);
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_LEAVES) + 1;
    localparam int CNT_W = $clog2(MAX_LEAVES + 1);

    logic [SUM_W-1:0] nw_mem [NCAP];
    logic [IDX_W-1:0] lc_mem [NCAP];
    logic [IDX_W-1:0] rc_mem [NCAP];
    logic [IDX_W-1:0] stk_mem [NCAP];
    logic [NCAP-1:0]  live_reg, live_next;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] leaf_reg, leaf_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             second_reg, second_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             have_reg, have_next;
    logic [IDX_W-1:0] sp_reg, sp_next;
    logic [IDX_W-1:0] emit_reg, emit_next;

    logic [SUM_W-1:0] rd_w;
    logic [IDX_W-1:0] rd_lc, rd_rc, rd_stk;
    logic [IDX_W-1:0] rd_addr, stk_rd_addr;

    logic             sc_clear, sc_probe, sc_found;
    logic [IDX_W-1:0] sc_best;
    logic [SUM_W-1:0] sc_best_w, a_w_reg;

    logic accept;
    logic [SUM_W-1:0] w_in;

    assign accept = start && !busy;
    assign w_in   = SUM_W'(weight[((WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W)-1:0]);

    htiw_scan #(.IDX_W(IDX_W), .SUM_W(SUM_W)) u_scan (
        .clk(clk), .rst_n(rst_n), .clear(sc_clear), .probe(sc_probe),
        .idx(ptr_reg), .w(nw_mem[ptr_reg]),
        .found(sc_found), .best_idx(sc_best), .best_w(sc_best_w)
    );

    // read port for walk
    assign rd_addr     = cur_reg;
    assign stk_rd_addr = sp_reg - 1'b1;
    assign rd_w   = nw_mem[rd_addr];
    assign rd_lc  = lc_mem[rd_addr];
    assign rd_rc  = rc_mem[rd_addr];
    assign rd_stk = stk_mem[stk_rd_addr];

    always_comb
    begin
        state_next  = state_reg;
        leaf_next   = leaf_reg;
        ovf_next    = ovf_reg;
        total_next  = total_reg;
        ptr_next    = ptr_reg;
        second_next = second_reg;
        a_next      = a_reg;
        cur_next    = cur_reg;
        have_next   = have_reg;
        sp_next     = sp_reg;
        emit_next   = emit_reg;
        live_next   = live_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (leaf_reg < CNT_W'(MAX_LEAVES))
                        leaf_next = leaf_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (last)
                        state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (leaf_reg == '0)
                begin
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    live_next = '0;
                    for (int i = 0; i < NCAP; i++)
                        if (i < int'(leaf_reg))
                            live_next[i] = 1'b1;
                    total_next  = IDX_W'(leaf_reg);
                    ptr_next    = '0;
                    second_next = 1'b0;
                    state_next  = (leaf_reg == CNT_W'(1)) ? ST_WPUSH : ST_SCAN;
                    cur_next    = '0;
                    have_next   = 1'b1;
                    sp_next     = '0;
                    emit_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (ptr_reg == total_reg)
                    state_next = ST_MERGE;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            ST_MERGE:
            begin
                live_next[sc_best] = 1'b0;
                ptr_next = '0;
                if (!second_reg)
                begin
                    a_next      = sc_best;
                    second_next = 1'b1;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    live_next[total_reg] = 1'b1;
                    total_next  = total_reg + 1'b1;
                    second_next = 1'b0;
                    if (total_reg == IDX_W'(2 * int'(leaf_reg) - 2))
                    begin
                        cur_next   = total_reg;
                        state_next = ST_WPUSH;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_WPUSH:
            begin
                if (have_reg)
                begin
                    sp_next = sp_reg + 1'b1;
                    if (cur_reg < IDX_W'(leaf_reg))
                        have_next = 1'b0;
                    else
                        cur_next = rd_lc;
                end
                else
                    state_next = ST_WPOP;
            end
            ST_WPOP:
            begin
                cur_next   = rd_stk;
                sp_next    = sp_reg - 1'b1;
                state_next = ST_WEMIT;
            end
            ST_WEMIT:
            begin
                emit_next = emit_reg + 1'b1;
                if (cur_reg < IDX_W'(leaf_reg))
                    have_next = 1'b0;
                else
                begin
                    cur_next  = rd_rc;
                    have_next = 1'b1;
                end
                if (emit_reg == IDX_W'(2 * int'(leaf_reg) - 2))
                begin
                    leaf_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                    state_next = (cur_reg < IDX_W'(leaf_reg)) ? ST_WPOP : ST_WPUSH;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_LOAD);
        sc_clear  = (state_reg == ST_MERGE) || (state_reg == ST_INIT);
        sc_probe  = (state_reg == ST_SCAN) && (ptr_reg != total_reg) && live_reg[ptr_reg];
        res_valid = (state_reg == ST_WEMIT);
        node_weight = OUT_W'(rd_w);
        final_res   = (state_reg == ST_WEMIT) && (emit_reg == IDX_W'(2 * int'(leaf_reg) - 2));
        dropped     = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            leaf_reg   <= '0;
            ovf_reg    <= 1'b0;
            total_reg  <= '0;
            ptr_reg    <= '0;
            second_reg <= 1'b0;
            a_reg      <= '0;
            cur_reg    <= '0;
            have_reg   <= 1'b0;
            sp_reg     <= '0;
            emit_reg   <= '0;
            live_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            leaf_reg   <= leaf_next;
            ovf_reg    <= ovf_next;
            total_reg  <= total_next;
            ptr_reg    <= ptr_next;
            second_reg <= second_next;
            a_reg      <= a_next;
            cur_reg    <= cur_next;
            have_reg   <= have_next;
            sp_reg     <= sp_next;
            emit_reg   <= emit_next;
            live_reg   <= live_next;
        end
    end

    // node stores: leaves on load, parents on the second pick, walk stack on push
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MERGE && !second_reg)
            a_w_reg <= sc_best_w;
        if (state_reg == ST_LOAD && accept && leaf_reg < CNT_W'(MAX_LEAVES))
            nw_mem[leaf_reg] <= w_in;
        else if (state_reg == ST_MERGE && second_reg)
        begin
            nw_mem[total_reg] <= a_w_reg + sc_best_w;
            lc_mem[total_reg] <= a_reg;
            rc_mem[total_reg] <= sc_best;
        end
        if (state_reg == ST_WPUSH && have_reg)
            stk_mem[sp_reg] <= cur_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> sc_found)
        else $error("merge without a live node");
    assert property (@(posedge clk) disable iff (!rst_n)
        final_res |=> !busy)
        else $error("busy after final result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WPOP) |-> (sp_reg != '0))
        else $error("walk stack underflow");
endmodule

[sim/huffman_tree_inorder_weights_unit_tb.sv]
// Testbench for huffman_tree_inorder_weights_unit: loads weight sets, predicts the
// in-order node weights of the Huffman tree and checks every result beat.
// Depends on htiw_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module huffman_tree_inorder_weights_unit_tb;
    import htiw_pkg::*;

    localparam int LEAF_CAP = MAX_LEAVES_DEF;
    localparam int NODE_MAX = 2 * LEAF_CAP;

    typedef struct packed {
        logic [OUT_W-1:0] node_w;
        logic             fin;
        logic             drop;
    } node_beat_t;

    typedef struct {
        logic [IN_W-1:0] w;
        logic            lst;
        int              n_exp;
        logic [OUT_W-1:0] w0;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [IN_W-1:0]  weight;
    logic             last;
    logic             res_valid;
    logic [OUT_W-1:0] node_weight;
    logic             final_res;
    logic             dropped;

    node_beat_t  pending_nodes[$];
    int          errors;
    int          send_gap_pct;

    // predictor state
    logic [31:0] tree_w[NODE_MAX];
    int          lchild[NODE_MAX];
    int          rchild[NODE_MAX];
    int          leaves_held;
    bit          overflowed;

    huffman_tree_inorder_weights_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .weight     (weight),
        .last       (last),
        .res_valid  (res_valid),
        .node_weight(node_weight),
        .final_res  (final_res),
        .dropped    (dropped)
    );

    always #6 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int take_smallest(ref bit live[NODE_MAX], input int total);
        int best;
        best = -1;
        for (int i = 0; i < total; i++)
            if (live[i] && (best < 0 || tree_w[i] < tree_w[best]))
                best = i;
        live[best] = 0;
        return best;
    endfunction

    // Fold one weight into the set; on last, build the tree and queue its walk.
    function automatic int predict_tree(input logic [IN_W-1:0] w, input logic lst);
        bit live[NODE_MAX];
        int n, total, a, b, cur, emitted;
        int stack[$];
        bit have_cur;
        node_beat_t nb;
        if (leaves_held < LEAF_CAP)
        begin
            tree_w[leaves_held] = 32'(w);
            leaves_held++;
        end
        else
            overflowed = 1;
        if (!lst)
            return 0;
        n = leaves_held;
        if (n == 0)
        begin
            overflowed = 0;
            return 0;
        end
        for (int i = 0; i < NODE_MAX; i++)
            live[i] = (i < n);
        total = n;
        for (int q = n; q > 1; q--)
        begin
            a = take_smallest(live, total);
            b = take_smallest(live, total);
            tree_w[total] = tree_w[a] + tree_w[b];
            lchild[total] = a;
            rchild[total] = b;
            live[total] = 1;
            total++;
        end
        cur = total - 1;
        have_cur = 1;
        emitted = 0;
        while (have_cur || stack.size() > 0)
        begin
            while (have_cur)
            begin
                stack.push_back(cur);
                if (cur < n)
                    have_cur = 0;
                else
                    cur = lchild[cur];
            end
            cur = stack.pop_back();
            nb.node_w = tree_w[cur][OUT_W-1:0];
            nb.fin = 0;
            nb.drop = overflowed;
            pending_nodes.push_back(nb);
            emitted++;
            if (cur < n)
                have_cur = 0;
            else
            begin
                cur = rchild[cur];
                have_cur = 1;
            end
        end
        pending_nodes[pending_nodes.size() - 1].fin = 1;
        leaves_held = 0;
        overflowed = 0;
        return emitted;
    endfunction

    always @(posedge clk)
    begin
        node_beat_t want;
        if (rst_n && res_valid)
        begin
            if (pending_nodes.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_nodes.pop_front();
                if (node_weight !== want.node_w)
                    report_mismatch($sformatf("node_weight %0d, want %0d",
                                              node_weight, want.node_w));
                if (final_res !== want.fin)
                    report_mismatch($sformatf("final_res %0b, want %0b", final_res, want.fin));
                if (dropped !== want.drop)
                    report_mismatch($sformatf("dropped %0b, want %0b", dropped, want.drop));
            end
        end
    end

    // Drive one beat and wait for it to be taken; gaps follow send_gap_pct.
    task automatic send_weight(input logic [IN_W-1:0] w, input logic lst, output int n_out);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        weight <= w;
        last   <= lst;
        do
            @(posedge clk);
        while (busy);
        n_out = predict_tree(w, lst);
        @(negedge clk);
    endtask

    task automatic send_set(input int n_leaves, input int mode);
        logic [IN_W-1:0] w;
        int n_out;
        for (int i = 0; i < n_leaves; i++)
        begin
            case (mode)
                0: w = IN_W'($urandom);
                1: w = IN_W'($urandom_range(7));
                2: w = IN_W'(32'hFFFF - $urandom_range(3));
                default: w = IN_W'($urandom_range(1) ? $urandom : $urandom_range(15));
            endcase
            send_weight(w, i == n_leaves - 1, n_out);
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        int n_out;
        int sets;
        int nl;
        clk = 0;
        rst_n = 0;
        start = 0;
        weight = '0;
        last = 0;
        errors = 0;
        send_gap_pct = 0;
        leaves_held = 0;
        overflowed = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: single leaves, zero and max weight, ties, two leaves; n_exp < 0 = unchecked
        rows.push_back('{16'h0000, 1'b1, 1, 20'h0});
        rows.push_back('{16'hFFFF, 1'b1, 1, 20'hFFFF});
        rows.push_back('{16'h0005, 1'b0, 0, 20'h0});
        rows.push_back('{16'h0005, 1'b1, 3, 20'h5});
        rows.push_back('{16'hFFFF, 1'b0, 0, 20'h0});
        rows.push_back('{16'hFFFF, 1'b0, 0, 20'h0});
        rows.push_back('{16'h0001, 1'b0, 0, 20'h0});
        rows.push_back('{16'hAAAA, 1'b0, 0, 20'h0});
        rows.push_back('{16'h5555, 1'b1, -1, 20'h0});
        foreach (rows[i])
        begin
            send_weight(rows[i].w, rows[i].lst, n_out);
            if (rows[i].n_exp >= 0 && n_out != rows[i].n_exp)
                report_mismatch($sformatf("row %0d gave %0d nodes", i, n_out));
            if (rows[i].n_exp > 0 && pending_nodes[pending_nodes.size() - n_out].node_w
                    !== rows[i].w0)
                report_mismatch($sformatf("row %0d first node off", i));
        end
        // full set of max weights (sum carries past 16 bits), then overflow with last dropped
        for (int i = 0; i < LEAF_CAP; i++)
            send_weight(16'hFFFF, i == LEAF_CAP - 1, n_out);
        for (int i = 0; i < LEAF_CAP + 2; i++)
            send_weight(IN_W'(i[3:0]), i == LEAF_CAP + 1, n_out);

        // random sets across idling phases
        sets = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_gap_pct = (ph == 1) ? 47 : (ph == 3) ? 8 : 0;
            for (int s = 0; s < 5; s++)
            begin
                if ($urandom_range(9) == 0)
                    nl = LEAF_CAP + $urandom_range(3);
                else
                    nl = $urandom_range(1, 9);
                send_set(nl, $urandom_range(3));
                sets++;
            end
        end
        start <= 1'b0;

        while (pending_nodes.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
rtl/core/htiw_pkg.sv
rtl/core/htiw_scan.sv
rtl/core/huffman_tree_inorder_weights_unit.sv
sim/huffman_tree_inorder_weights_unit_tb.sv
